### hdl/multiturn_angle_velocity_tracker_core_assert.svh
// Assertion macros for the multiturn angle/velocity tracker.
// Used inside modules that have clk_i and rst_ni in scope.
`ifndef MULTITURN_ANGLE_VELOCITY_TRACKER_CORE_ASSERT_SVH
`define MULTITURN_ANGLE_VELOCITY_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MAVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mavt assertion failed");

// Next-cycle implication, disabled during reset.
`define MAVT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mavt assertion failed");

`endif

### hdl/mavt_pkg.sv
// Package for the multiturn angle/velocity tracker: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps

package mavt_pkg;

  localparam int ANGLE_BITS  = 14;            // valid range 8..14
  localparam int RESP_W      = 16;
  localparam int TICK_W      = 32;
  localparam int ANGLE_OUT_W = 14;
  localparam int ERR_BIT     = 14;
  localparam int TURN_W      = 8;
  localparam int DEG_W       = 9;
  localparam int ACC_W       = 17;
  localparam int VEL_W       = 29;
  localparam int DELTA_W     = ANGLE_BITS + 2;
  // magnitude <= 2^(AB-1), times K < 2^15, shifted by 14-AB: below 2^28
  localparam int NUM_W       = 28;
  localparam int VEL_SH      = 14 - ANGLE_BITS;
  localparam int CNT_W       = $clog2(NUM_W);

  localparam logic [14:0] VEL_K        = 15'd25133;
  localparam logic [8:0]  DEG_PER_TURN = 9'd360;

  localparam logic signed [DELTA_W-1:0] RES  = DELTA_W'(1 << ANGLE_BITS);
  localparam logic signed [DELTA_W-1:0] HALF = DELTA_W'(1 << (ANGLE_BITS - 1));

  localparam logic signed [TURN_W-1:0] TURN_MAX = 8'sd127;
  localparam logic signed [TURN_W-1:0] TURN_MIN = -8'sd128;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/mavt_if.sv
// Valid/ready channel interfaces for the tracker's input and result items.
// Depends on mavt_pkg.
`timescale 1ns / 1ps

interface mavt_in_if;
  import mavt_pkg::*;

  logic                valid;
  logic                ready;
  logic [RESP_W-1:0]   response_word;
  logic [TICK_W-1:0]   tick_ms;

  modport source (output valid, output response_word, output tick_ms, input ready);
  modport sink   (input valid, input response_word, input tick_ms, output ready);
endinterface

interface mavt_out_if;
  import mavt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ANGLE_OUT_W-1:0]   angle_raw;
  logic                     error_flag;
  logic signed [TURN_W-1:0] turn_count;
  logic [DEG_W-1:0]         angle_degree;
  logic signed [ACC_W-1:0]  accumulated_degree;
  logic signed [VEL_W-1:0]  velocity_q16;

  modport source (output valid, output angle_raw, output error_flag, output turn_count,
                  output angle_degree, output accumulated_degree, output velocity_q16,
                  input ready);
  modport sink   (input valid, input angle_raw, input error_flag, input turn_count,
                  input angle_degree, input accumulated_degree, input velocity_q16,
                  output ready);
endinterface

### hdl/mavt_div.sv
// Restoring divider, one quotient bit per cycle over the NUM_W-bit dividend.
// Depends on mavt_pkg.
`timescale 1ns / 1ps

module mavt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mavt_pkg::NUM_W-1:0]    dividend_i,
  input  logic [mavt_pkg::TICK_W-1:0]   divisor_i,
  output logic [mavt_pkg::NUM_W-1:0]    quotient_o,
  output mavt_pkg::div_stat_t           stat_o
);
  import mavt_pkg::*;

  logic [TICK_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [TICK_W-1:0] den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [TICK_W:0]   trial;
  logic              ge;

  // shift in next dividend bit, compare against divisor
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_d = ge ? TICK_W'(trial - {1'b0, den_q}) : TICK_W'(trial);
  assign quo_d = {quo_q[NUM_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign stat_o     = '{busy: busy_q, done: done_q};

endmodule

### hdl/multiturn_angle_velocity_tracker_core.sv
// Channel   | Dir | Payload                                         | Handshake
// in_i      | in  | response_word[15:0], tick_ms[31:0]              | valid/ready
// out_o     | out | angle_raw, error_flag, turn_count, angle_degree,| valid/ready
//           |     | accumulated_degree, velocity_q16                |
//
// Sequence: accept, multiply, 28-step restoring divide, result load when a velocity is
//   computed; the divide is skipped when velocity is held (first item, or no elapsed
//   ms). The single divider yields one quotient bit per cycle.
// One item at a time: in_i.ready is high only while the sequencer is idle.
// The result sits in an output register, so a new item is taken while it waits.
// Reset: asynchronous, active low; clears turns, last angle/tick, velocity, primed.
// A stalled out_o holds the sequencer in its result state until the slot frees.
//
// Depends on mavt_pkg, mavt_if, mavt_div and the assertion macro header.
`timescale 1ns / 1ps
`include "multiturn_angle_velocity_tracker_core_assert.svh"

module multiturn_angle_velocity_tracker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mavt_in_if.sink    in_i,
  mavt_out_if.source out_o
);
  import mavt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  // tracking state
  logic                      primed_q;
  logic [ANGLE_BITS-1:0]     last_angle_q;
  logic [TICK_W-1:0]         last_tick_q;
  logic signed [TURN_W-1:0]  turns_q;
  logic signed [VEL_W-1:0]   vel_q;

  // per-item working registers
  logic                      err_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [TICK_W-1:0]         dt_q;
  logic                      do_div_q;
  logic                      neg_q;
  logic [DEG_W-1:0]          deg_q;

  // result register
  logic                      out_valid_q;
  logic [ANGLE_OUT_W-1:0]    o_angle_q;
  logic                      o_err_q;
  logic signed [TURN_W-1:0]  o_turns_q;
  logic [DEG_W-1:0]          o_deg_q;
  logic signed [ACC_W-1:0]   o_acc_q;
  logic signed [VEL_W-1:0]   o_vel_q;

  logic                      in_fire;
  logic                      out_load;
  logic [ANGLE_BITS-1:0]     angle_in;
  logic signed [DELTA_W-1:0] delta_raw;
  logic signed [DELTA_W-1:0] delta_unw;
  logic signed [TURN_W-1:0]  turns_unw;
  logic [TICK_W-1:0]         dt_in;
  logic [ANGLE_BITS-1:0]     mag;
  logic [NUM_W-1:0]          num_d;
  logic [ANGLE_BITS+8:0]     deg_full;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [VEL_W-1:0]   vel_new;
  logic                      div_start;
  logic [NUM_W-1:0]          div_quo;
  div_stat_t                 div_stat;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // Unwrap: a jump beyond half a turn is a wrap. Exactly half a turn is not.
  assign angle_in  = in_i.response_word[ANGLE_BITS-1:0];
  assign delta_raw = $signed(DELTA_W'(angle_in)) - $signed(DELTA_W'(last_angle_q));
  assign dt_in     = in_i.tick_ms - last_tick_q;

  always_comb begin
    delta_unw = delta_raw;
    turns_unw = turns_q;
    if (delta_raw < -HALF) begin
      delta_unw = delta_raw + RES;
      if (turns_q != TURN_MAX) turns_unw = turns_q + 8'sd1;
    end else if (delta_raw > HALF) begin
      delta_unw = delta_raw - RES;
      if (turns_q != TURN_MIN) turns_unw = turns_q - 8'sd1;
    end
  end

  // |delta| * K, scaled so the divide by dt lands in signed Q12.16 rad/s;
  // the product feeds the divider directly when it loads in ST_MUL
  assign mag      = neg_q ? ANGLE_BITS'(-delta_q) : ANGLE_BITS'(delta_q);
  assign num_d    = (NUM_W'(mag) * NUM_W'(VEL_K)) << VEL_SH;
  assign deg_full = (ANGLE_BITS + 9)'(last_angle_q) * (ANGLE_BITS + 9)'(DEG_PER_TURN);

  assign acc_d = $signed(ACC_W'(deg_q))
               + ACC_W'(turns_q) * $signed(ACC_W'(DEG_PER_TURN));
  assign vel_new = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  assign div_start = (state_q == ST_MUL) && do_div_q;

  mavt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_d),
    .divisor_i  (dt_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      primed_q     <= 1'b0;
      last_angle_q <= '0;
      last_tick_q  <= '0;
      turns_q      <= '0;
      vel_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            primed_q     <= 1'b1;
            last_angle_q <= angle_in;
            last_tick_q  <= in_i.tick_ms;
            if (primed_q) turns_q <= turns_unw;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= do_div_q ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            vel_q   <= vel_new;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // working and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q    <= in_i.response_word[ERR_BIT];
      delta_q  <= delta_unw;
      neg_q    <= delta_unw < 0;
      dt_q     <= dt_in;
      do_div_q <= primed_q && (dt_in != '0);
    end
    if (state_q == ST_MUL) begin
      deg_q <= DEG_W'(deg_full >> ANGLE_BITS);
    end
    if (out_load) begin
      o_angle_q <= ANGLE_OUT_W'(last_angle_q);
      o_err_q   <= err_q;
      o_turns_q <= turns_q;
      o_deg_q   <= deg_q;
      o_acc_q   <= acc_d;
      o_vel_q   <= vel_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.angle_raw          = o_angle_q;
  assign out_o.error_flag         = o_err_q;
  assign out_o.turn_count         = o_turns_q;
  assign out_o.angle_degree       = o_deg_q;
  assign out_o.accumulated_degree = o_acc_q;
  assign out_o.velocity_q16       = o_vel_q;

  // one item in flight: after an accept the input side closes
  `MAVT_ASSERT_NXT(a_one_in_flight, in_fire, !in_i.ready)
  // divider is only kicked while free
  `MAVT_ASSERT_IMP(a_div_free, div_start, !div_stat.busy)
  // velocity only moves when a divide completes
  `MAVT_ASSERT_NXT(a_vel_hold, !div_stat.done, vel_q == $past(vel_q))
  // turn count moves by at most one per item
  `MAVT_ASSERT_NXT(a_turn_step, 1'b1,
    (turns_q == $past(turns_q)) || (turns_q == $past(turns_q) + 8'sd1) ||
    (turns_q == $past(turns_q) - 8'sd1))

endmodule

### bench/multiturn_angle_velocity_tracker_core_tb.sv
// Testbench for multiturn_angle_velocity_tracker_core: random and directed sensor items,
// a scoreboard class that predicts angle, turns, degrees and velocity per accepted item.
// Depends on mavt_pkg, mavt_if and the tracker RTL.
`timescale 1ns / 1ps

module multiturn_angle_velocity_tracker_core_tb;
  import mavt_pkg::*;

  localparam int          FULL_TURN       = 1 << ANGLE_BITS;
  localparam int          HALF_TURN       = FULL_TURN / 2;
  localparam int          VEL_GAIN        = 25133;   // 2*pi*1000*65536/16384
  localparam int          DEG_TURN        = 360;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned RANDOM_ITEMS    = 1880;
  localparam int          DIRECTED_ITEMS  = 18;

  typedef enum {SEG_SPIN, SEG_JITTER, SEG_NOISE} seg_kind_e;

  typedef struct {
    logic [ANGLE_OUT_W-1:0]   angle;
    logic                     err;
    logic signed [TURN_W-1:0] turns;
    logic [DEG_W-1:0]         degree;
    logic signed [ACC_W-1:0]  acc_degree;
    logic signed [VEL_W-1:0]  velocity;
  } tracker_reading_t;

  // Predicts each reading from the accepted samples and checks the block's readings
  // against them in order.
  class angle_tracker_checker;
    tracker_reading_t expected_readings[$];
    int unsigned      failures;
    logic [13:0]      last_angle;
    logic [31:0]      last_tick;
    int               turns;
    int               velocity;
    bit               primed;

    function new();
      failures   = 0;
      last_angle = '0;
      last_tick  = '0;
      turns      = 0;
      velocity   = 0;
      primed     = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction

    function void log_sample(logic [RESP_W-1:0] word, logic [TICK_W-1:0] tick);
      logic [13:0]       angle;
      logic [31:0]       elapsed;
      int                delta;
      int unsigned       deg;
      longint unsigned   mag;
      longint unsigned   num;
      longint unsigned   den;
      longint unsigned   quo;
      tracker_reading_t  r;
      angle = word[13:0] & 14'(FULL_TURN - 1);
      if (!primed) begin
        primed = 1'b1;
      end else begin
        delta   = int'({18'd0, angle}) - int'({18'd0, last_angle});
        elapsed = tick - last_tick;
        // more than half a turn either way means the angle wrapped
        if (delta < -HALF_TURN) begin
          if (turns < 127) turns++;
          delta += FULL_TURN;
        end else if (delta > HALF_TURN) begin
          if (turns > -128) turns--;
          delta -= FULL_TURN;
        end
        if (elapsed != 0) begin
          mag      = (delta < 0) ? longint'(-delta) : longint'(delta);
          num      = (mag * VEL_GAIN) << (16 - ANGLE_BITS);
          den      = {32'd0, elapsed} << 2;
          quo      = num / den;
          velocity = (delta < 0) ? -int'(quo) : int'(quo);
        end
      end
      last_angle = angle;
      last_tick  = tick;
      deg          = (int'({18'd0, angle}) * DEG_TURN) >> ANGLE_BITS;
      r.angle      = angle;
      r.err        = word[14];
      r.turns      = TURN_W'(turns);
      r.degree     = DEG_W'(deg);
      r.acc_degree = ACC_W'(int'(deg) + turns * DEG_TURN);
      r.velocity   = VEL_W'(velocity);
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_reading(tracker_reading_t got);
      tracker_reading_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading, expected none actual angle %0d", $time,
                 got.angle);
        failures++;
        return;
      end
      want = expected_readings.pop_front();
      compare_field("angle_raw", want.angle, got.angle);
      compare_field("error_flag", want.err, got.err);
      compare_field("turn_count", want.turns, got.turns);
      compare_field("angle_degree", want.degree, got.degree);
      compare_field("accumulated_degree", want.acc_degree, got.acc_degree);
      compare_field("velocity_q16", want.velocity, got.velocity);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;

  mavt_in_if  in_if ();
  mavt_out_if out_if ();

  multiturn_angle_velocity_tracker_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  angle_tracker_checker sb = new();

  bit          no_gaps       = 1'b0;  // both sides run back to back while set
  bit          hold_off_req  = 1'b0;  // asks the receiver for one long hold-off
  int unsigned cycle_count   = 0;

  // Directed samples: priming item, exact half-turn jumps both ways, wraps just past
  // half a turn, no elapsed time, tick wrap, error and parity bits, extreme angles.
  logic [RESP_W-1:0] dir_word [DIRECTED_ITEMS] = '{
    16'hFFFF, 16'h0000, 16'h2000, 16'h0000, 16'h2001, 16'h4000, 16'h8000, 16'h3FFF,
    16'h1FFF, 16'h7FFF, 16'h0000, 16'hBFFF, 16'h2AAA, 16'h1555, 16'h3FFF, 16'h0001,
    16'h3FFF, 16'hC000};
  logic [TICK_W-1:0] dir_tick [DIRECTED_ITEMS] = '{
    32'd100, 32'd101, 32'd101, 32'd102, 32'd103, 32'd104, 32'hFFFF_FFFE, 32'h0000_0001,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h5555_5555,
    32'hAAAA_AAAA, 32'hAAAA_AAAB, 32'hAAAA_AAAC, 32'hAAAA_AAAC, 32'h7FFF_FFFF};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 10);
  endfunction

  // Offers one item after a random gap and waits until the block takes it.
  task automatic push_sample(input logic [RESP_W-1:0] word, input logic [TICK_W-1:0] tick);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid         <= 1'b1;
    in_if.response_word <= word;
    in_if.tick_ms       <= tick;
    do @(posedge clk_i); while (!in_if.ready);
    sb.log_sample(word, tick);
  endtask

  // Receiver: random stall per reading, one long hold-off on request.
  initial begin
    tracker_reading_t got;
    int unsigned      stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall        = HOLD_OFF_CYCLES;
      end
      repeat (stall) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.angle      = out_if.angle_raw;
      got.err        = out_if.error_flag;
      got.turns      = out_if.turn_count;
      got.degree     = out_if.angle_degree;
      got.acc_degree = out_if.accumulated_degree;
      got.velocity   = out_if.velocity_q16;
      sb.check_reading(got);
    end
  end

  // Sender: directed samples, then segments of spinning, jitter and noise.
  initial begin
    seg_kind_e         seg_kind;
    int unsigned       seg_left;
    int unsigned       seg_no;
    int unsigned       step_lo;
    int unsigned       step_hi;
    bit                spin_up;
    logic [13:0]       cur_angle;
    logic [TICK_W-1:0] cur_tick;
    logic [RESP_W-1:0] word;
    int unsigned       pick;
    in_if.valid         = 1'b0;
    in_if.response_word = '0;
    in_if.tick_ms       = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_ITEMS; i++) push_sample(dir_word[i], dir_tick[i]);

    cur_angle = dir_word[DIRECTED_ITEMS-1][13:0];
    cur_tick  = dir_tick[DIRECTED_ITEMS-1];
    seg_left  = 0;
    seg_no    = 0;
    seg_kind  = SEG_SPIN;
    step_lo   = 0;
    step_hi   = 0;
    spin_up   = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        // The first two segments spin hard enough to pin the turn count at both ends.
        if (seg_no < 2) begin
          seg_kind = SEG_SPIN;
          spin_up  = (seg_no == 0);
          seg_left = (seg_no == 0) ? 320 : 650;
          step_lo  = 6000;
          step_hi  = 8191;
        end else begin
          pick     = $urandom_range(0, 9);
          seg_kind = (pick < 6) ? SEG_SPIN : (pick < 8) ? SEG_JITTER : SEG_NOISE;
          spin_up  = 1'($urandom_range(0, 1));
          seg_left = (seg_kind == SEG_NOISE) ? $urandom_range(5, 20) : $urandom_range(10, 80);
          step_hi  = $urandom_range(1, FULL_TURN - 1);
          step_lo  = $urandom_range(0, step_hi);
        end
        seg_no++;
      end
      seg_left--;

      if (n == 150) hold_off_req = 1'b1;
      no_gaps = (n >= 400 && n < 520) || (n >= 1300 && n < 1400);
      if (n == 1000) begin
        // drain the block completely before going on
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end

      case (seg_kind)
        SEG_SPIN: begin
          if (spin_up) cur_angle = cur_angle + 14'($urandom_range(step_lo, step_hi));
          else         cur_angle = cur_angle - 14'($urandom_range(step_lo, step_hi));
        end
        SEG_JITTER: begin
          cur_angle = cur_angle + 14'($urandom_range(0, 100)) - 14'd50;
        end
        default: begin
        end
      endcase

      if (seg_kind == SEG_NOISE) begin
        word      = RESP_W'($urandom);
        cur_tick  = $urandom;
        cur_angle = word[13:0];
      end else begin
        word = {1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0), cur_angle};
        pick = $urandom_range(0, 63);
        if (pick < 4)        cur_tick = cur_tick;
        else if (pick == 4)  cur_tick = $urandom;
        else if (pick == 5)  cur_tick = cur_tick + $urandom_range(1000, 100000);
        else                 cur_tick = cur_tick + $urandom_range(1, 8);
      end
      push_sample(word, cur_tick);
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    no_gaps = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
